>>> hw/rtl/orl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offered-rate limiter package
// Field widths, refusal codes, fixed constants and the control and status
// structs shared by the limiter core and its serial arithmetic units.
// ----------------------------------------------------------------------------
package orl_pkg;

   // field widths
   localparam int NOW_W   = 32;
   localparam int LEN_W   = 16;
   localparam int BAUD_W  = 22;
   localparam int BYTES_W = 19;
   localparam int RATE_W  = 19;

   // refusal codes
   localparam logic [1:0] REFUSE_NONE = 2'd0;
   localparam logic [1:0] REFUSE_DEBT = 2'd1;
   localparam logic [1:0] REFUSE_FULL = 2'd2;

   // line rate is baud / 10 bytes per second
   localparam int LINE_DIV = 10;
   // drain credit is elapsed ms * rate / 1000
   localparam int MS_PER_S = 1000;
   // window length in milliseconds
   localparam logic [NOW_W-1:0] WINDOW_MS = 32'd1000;
   // largest line rate the baud register can give
   localparam logic [RATE_W-1:0] RATE_MAX = 19'd419430;

   // serial divider geometry
   localparam int DVD_W  = 22;
   localparam int REM_W  = 16;
   localparam int STEP_W = 5;

   // serial multiplier geometry: product is tracked up to 2^PROD_W
   localparam int PROD_W = 29;

   // step counts of the three divisions
   localparam logic [STEP_W-1:0] RATE_STEPS = 5'd22;
   localparam logic [STEP_W-1:0] DRN_STEPS  = 5'd20;
   localparam logic [STEP_W-1:0] CEIL_STEPS = 5'd17;

   // start request to a serial unit
   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } seq_cmd_type;

   // status of a serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } seq_sts_type;

endpackage

>>> hw/rtl/orl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offered-rate limiter channels
// Valid/ready channels for offer words and for decision words.
// ----------------------------------------------------------------------------
interface orl_req_if;
   import orl_pkg::*;

   logic             valid;
   logic             ready;
   logic [NOW_W-1:0] now_ms;
   logic [LEN_W-1:0] msg_len;

   modport source (output valid, output now_ms, output msg_len, input ready);
   modport sink   (input valid, input now_ms, input msg_len, output ready);
endinterface

interface orl_rsp_if;
   import orl_pkg::*;

   logic               valid;
   logic               ready;
   logic               admitted;
   logic [1:0]         refusal;
   logic [BYTES_W-1:0] bytes_used;

   modport source (output valid, output admitted, output refusal, output bytes_used,
                   input ready);
   modport sink   (input valid, input admitted, input refusal, input bytes_used,
                   output ready);
endinterface

>>> hw/rtl/orl_sdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle. The dividend is loaded left-aligned, the
// quotient shifts in from the right, so after the requested number of steps
// the register holds the quotient alone.
// ----------------------------------------------------------------------------
module orl_sdiv (
   input  logic                         clock,
   input  logic                         reset,
   input  orl_pkg::seq_cmd_type         cmd,
   input  logic [orl_pkg::DVD_W-1:0]    dividend,
   input  logic [orl_pkg::REM_W-1:0]    rem_init,
   input  logic [orl_pkg::REM_W-1:0]    divisor,
   output orl_pkg::seq_sts_type         sts,
   output logic [orl_pkg::DVD_W-1:0]    quotient
);
   import orl_pkg::*;

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W:0]    trial;
   logic              fits;

   // one restoring step
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         dvd_in   = dividend;
         rem_in   = rem_init;
         dsr_in   = divisor;
         count_in = cmd.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[DVD_W-2:0], fits};
         rem_in   = fits ? REM_W'(trial - {1'b0, dsr_ff}) : trial[REM_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      count_ff <= count_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> hw/rtl/orl_smul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial saturating multiplier
// Shift-and-add over the rate bits, most significant first. The product is
// only wanted below 2^PROD_W; once it reaches that it is flagged saturated.
// Multiplicand must be below 2^PROD_W.
// ----------------------------------------------------------------------------
module orl_smul (
   input  logic                          clock,
   input  logic                          reset,
   input  orl_pkg::seq_cmd_type          cmd,
   input  logic [orl_pkg::PROD_W-1:0]    mcand,
   input  logic [orl_pkg::RATE_W-1:0]    mplier,
   output orl_pkg::seq_sts_type          sts,
   output logic [orl_pkg::PROD_W-1:0]    product,
   output logic                          saturated
);
   import orl_pkg::*;

   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [RATE_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic              sat_ff, sat_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [PROD_W+1:0] sum;

   // double and add the multiplicand when the next rate bit is set
   assign sum = {1'b0, acc_ff, 1'b0}
              + (mplier_ff[RATE_W-1] ? (PROD_W+2)'(mcand_ff) : '0);

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      sat_in    = sat_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = '0;
         sat_in    = 1'b0;
         count_in  = cmd.steps;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         mplier_in = {mplier_ff[RATE_W-2:0], 1'b0};
         acc_in    = sum[PROD_W-1:0];
         sat_in    = sat_ff || (sum[PROD_W+1:PROD_W] != 2'b00);
         count_in  = count_ff - 1'b1;
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      sat_ff    <= sat_in;
      count_ff  <= count_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign product   = acc_ff;
   assign saturated = sat_ff;

endmodule

>>> hw/rtl/offered_rate_admission_limiter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offered-rate admission limiter core
// Leaky-bucket admission decision per offered message, with window drain,
// window roll-over and debt parking for oversize offers.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake           word
//   req_bus   in    valid / ready       now_ms, msg_len
//   rsp_bus   out   valid / ready       admitted, refusal, bytes_used
//   csr_*     in    csr_wr_en           line_baud
//
// One offer at a time. Disabled limiter, empty offers and debt refusals go from
// acceptance straight to the result registers, then to the output register once
// it is free; a full decision first runs the shared serial divider (22 steps
// for the line rate, 20 for the drain credit, 17 for the debt length) and the
// 19-step multiplier as the offer needs them.
// Reset is synchronous and clears the window, debt and baud registers.
// A held result stalls the core only when the next decision is ready.
// ----------------------------------------------------------------------------
module offered_rate_admission_limiter_core (
   input  logic                          clock,
   input  logic                          reset,
   orl_req_if.sink                       req_bus,
   orl_rsp_if.source                     rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [orl_pkg::BAUD_W-1:0]    csr_wr_data
);
   import orl_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RATE  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_ROLL  = 3'd4;
   localparam logic [2:0] S_CEIL  = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [BAUD_W-1:0]  baud_ff, baud_in;
   logic [NOW_W-1:0]   ws_ff, ws_in;
   logic [BYTES_W-1:0] wb_ff, wb_in;
   logic [NOW_W-1:0]   debt_ff, debt_in;
   logic [NOW_W-1:0]   now_ff, now_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic               res_adm_ff, res_adm_in;
   logic [1:0]         res_ref_ff, res_ref_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_adm_ff, rsp_adm_in;
   logic [1:0]         rsp_ref_ff, rsp_ref_in;
   logic [BYTES_W-1:0] rsp_bytes_ff, rsp_bytes_in;

   // serial unit hookup
   seq_cmd_type        div_cmd, mul_cmd;
   seq_sts_type        div_sts, mul_sts;
   logic [DVD_W-1:0]   div_dvd, div_q;
   logic [REM_W-1:0]   div_rem0, div_dsr;
   logic [PROD_W-1:0]  mul_prod;
   logic               mul_sat;

   // decision terms
   logic               req_fire;
   logic [NOW_W-1:0]   debt_diff;
   logic               debt_pend;
   logic               limiter_off;
   logic [NOW_W-1:0]   elapsed;
   logic               drain_en;
   logic               elapsed_big;
   logic               roll_due;
   logic [BYTES_W-1:0] wb_roll;
   logic               len_big;
   logic [BYTES_W:0]   fit_sum;
   logic               win_full;
   logic [LEN_W:0]     ceil_num;
   logic [NOW_W-1:0]   span;
   logic               emit_go;

   orl_sdiv u_sdiv (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dvd),
      .rem_init (div_rem0),
      .divisor  (div_dsr),
      .sts      (div_sts),
      .quotient (div_q)
   );

   orl_smul u_smul (
      .clock     (clock),
      .reset     (reset),
      .cmd       (mul_cmd),
      .mcand     (elapsed[PROD_W-1:0]),
      .mplier    (div_q[RATE_W-1:0]),
      .sts       (mul_sts),
      .product   (mul_prod),
      .saturated (mul_sat)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // checks on the incoming word
   assign debt_diff   = req_bus.now_ms - debt_ff;
   assign debt_pend   = (debt_ff != '0) && debt_diff[NOW_W-1];
   assign limiter_off = baud_ff < BAUD_W'(LINE_DIV);

   // drain and roll terms on the held word
   assign elapsed     = now_ff - ws_ff;
   assign drain_en    = (ws_ff != '0) && (elapsed != '0) && !elapsed[NOW_W-1]
                        && (wb_ff != '0);
   assign elapsed_big = elapsed[NOW_W-2:PROD_W] != '0;
   assign roll_due    = (debt_ff != '0) || (elapsed >= WINDOW_MS);
   assign wb_roll     = roll_due ? '0 : wb_ff;

   // admission terms
   assign len_big  = RATE_W'(len_ff) > rate_ff;
   assign fit_sum  = {1'b0, wb_roll} + (BYTES_W+1)'(len_ff);
   assign win_full = fit_sum > {1'b0, rate_ff};
   assign ceil_num = (LEN_W+1)'(len_ff) + (LEN_W+1)'(rate_ff[LEN_W-1:0]) - 1'b1;
   assign span     = NOW_W'({15'd0, div_q[LEN_W:0]} * WINDOW_MS);

   assign emit_go  = !rsp_valid_ff || rsp_bus.ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      baud_in      = csr_wr_en ? csr_wr_data : baud_ff;
      ws_in        = ws_ff;
      wb_in        = wb_ff;
      debt_in      = debt_ff;
      now_in       = now_ff;
      len_in       = len_ff;
      rate_in      = rate_ff;
      res_adm_in   = res_adm_ff;
      res_ref_in   = res_ref_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_adm_in   = rsp_adm_ff;
      rsp_ref_in   = rsp_ref_ff;
      rsp_bytes_in = rsp_bytes_ff;
      div_cmd      = '{start: 1'b0, steps: RATE_STEPS};
      mul_cmd      = '{start: 1'b0, steps: STEP_W'(RATE_W)};
      div_dvd      = baud_ff;
      div_rem0     = '0;
      div_dsr      = REM_W'(LINE_DIV);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               now_in = req_bus.now_ms;
               len_in = req_bus.msg_len;
               if ((req_bus.msg_len == '0) || limiter_off) begin
                  res_adm_in = 1'b1;
                  res_ref_in = REFUSE_NONE;
                  state_in   = S_EMIT;
               end else if (debt_pend) begin
                  res_adm_in = 1'b0;
                  res_ref_in = REFUSE_DEBT;
                  state_in   = S_EMIT;
               end else begin
                  // line rate = baud / 10
                  div_cmd.start = 1'b1;
                  state_in      = S_RATE;
               end
            end
         end
         S_RATE: begin
            if (div_sts.done) begin
               rate_in = div_q[RATE_W-1:0];
               if (!drain_en) begin
                  state_in = S_ROLL;
               end else if (elapsed_big) begin
                  // credit certainly exceeds any window count
                  wb_in    = '0;
                  state_in = S_ROLL;
               end else begin
                  mul_cmd.start = 1'b1;
                  state_in      = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mul_sts.done) begin
               if (mul_sat) begin
                  wb_in    = '0;
                  state_in = S_ROLL;
               end else begin
                  // credit = product / 1000; top bits preload the remainder
                  div_cmd.start = 1'b1;
                  div_cmd.steps = DRN_STEPS;
                  div_dvd       = {mul_prod[DRN_STEPS-1:0], 2'b00};
                  div_rem0      = REM_W'(mul_prod[PROD_W-1:DRN_STEPS]);
                  div_dsr       = REM_W'(MS_PER_S);
                  state_in      = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (div_sts.done) begin
               if (div_q >= DVD_W'(wb_ff)) begin
                  wb_in = '0;
               end else begin
                  wb_in = wb_ff - div_q[BYTES_W-1:0];
               end
               state_in = S_ROLL;
            end
         end
         S_ROLL: begin
            // clear an expired debt or open a new window
            if (roll_due) begin
               ws_in = now_ff;
            end
            debt_in = '0;
            if (len_big) begin
               // oversize offer: debt of ceil(len / rate) windows
               wb_in         = wb_roll;
               div_cmd.start = 1'b1;
               div_cmd.steps = CEIL_STEPS;
               div_dvd       = {ceil_num, 5'd0};
               div_dsr       = rate_ff[REM_W-1:0];
               state_in      = S_CEIL;
            end else if (win_full) begin
               wb_in      = wb_roll;
               res_adm_in = 1'b0;
               res_ref_in = REFUSE_FULL;
               state_in   = S_EMIT;
            end else begin
               wb_in      = fit_sum[BYTES_W-1:0];
               res_adm_in = 1'b1;
               res_ref_in = REFUSE_NONE;
               state_in   = S_EMIT;
            end
         end
         S_CEIL: begin
            if (div_sts.done) begin
               debt_in    = now_ff + span;
               res_adm_in = 1'b1;
               res_ref_in = REFUSE_NONE;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_adm_in   = res_adm_ff;
               rsp_ref_in   = res_ref_ff;
               rsp_bytes_in = wb_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and limiter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         baud_ff      <= '0;
         ws_ff        <= '0;
         wb_ff        <= '0;
         debt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         baud_ff      <= baud_in;
         ws_ff        <= ws_in;
         wb_ff        <= wb_in;
         debt_ff      <= debt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // held word, rate and result payload
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      len_ff       <= len_in;
      rate_ff      <= rate_in;
      res_adm_ff   <= res_adm_in;
      res_ref_ff   <= res_ref_in;
      rsp_adm_ff   <= rsp_adm_in;
      rsp_ref_ff   <= rsp_ref_in;
      rsp_bytes_ff <= rsp_bytes_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.admitted   = rsp_adm_ff;
   assign rsp_bus.refusal    = rsp_ref_ff;
   assign rsp_bus.bytes_used = rsp_bytes_ff;

   // admitted flag and refusal code agree
   a_adm_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_adm_ff == (rsp_ref_ff == REFUSE_NONE)))
      else $error("admitted flag disagrees with refusal code");

   // window count never exceeds the largest line rate
   a_wb_bound: assert property (@(posedge clock) disable iff (reset)
      wb_ff <= RATE_MAX)
      else $error("window byte count out of range");

   // divider and multiplier never run together
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(div_sts.busy && mul_sts.busy))
      else $error("divider and multiplier busy at once");

   // a new decision is only loaded when the output slot is free
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && rsp_valid_ff && !rsp_bus.ready |=> (state_ff == S_EMIT))
      else $error("result overwritten while held");

endmodule

>>> tb/orl_decision_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offered-rate limiter decision checker
// Watches the offer and decision channels and the baud register port, keeps
// its own copy of the window, debt and baud state, works out the decision
// for every accepted offer word and compares it field by field with the
// decision words in the order they leave the core.
// ----------------------------------------------------------------------------
module orl_decision_checker (
   input  logic                        clock,
   input  logic                        reset,
   orl_req_if                          req_mon,
   orl_rsp_if                          rsp_mon,
   input  logic                        csr_wr_en,
   input  logic [orl_pkg::BAUD_W-1:0]  csr_wr_data,
   output int                          fail_count,
   output int                          pending_count
);
   import orl_pkg::*;

   typedef struct packed {
      logic               admitted;
      logic [1:0]         refusal;
      logic [BYTES_W-1:0] bytes_used;
   } decision_type;

   // mirrored limiter state
   logic [BAUD_W-1:0] line_baud_q;
   logic [NOW_W-1:0]  win_start;
   logic [31:0]       win_bytes;
   logic [NOW_W-1:0]  debt_end;

   decision_type decisions_due[$];

   function automatic logic since_is_negative(input logic [NOW_W-1:0] diff);
      return diff[NOW_W-1];
   endfunction

   // decision for one offer; updates the mirrored state as the core would
   function automatic decision_type judge_offer(input logic [NOW_W-1:0] now,
                                                input logic [LEN_W-1:0] len);
      logic [RATE_W-1:0] rate;
      logic [NOW_W-1:0]  since;
      logic [63:0]       credit;
      logic [31:0]       n_windows;
      logic [63:0]       span;
      decision_type      d;

      rate         = RATE_W'(line_baud_q / LINE_DIV);
      d.admitted   = 1'b1;
      d.refusal    = REFUSE_NONE;
      d.bytes_used = win_bytes[BYTES_W-1:0];

      // limiter off or empty offer: pass straight through
      if (len == '0 || rate == '0) return d;

      // debt still running
      if (debt_end != '0 && since_is_negative(now - debt_end)) begin
         d.admitted = 1'b0;
         d.refusal  = REFUSE_DEBT;
         return d;
      end

      // drain credit from the window start, floored at zero
      since = now - win_start;
      if (win_start != '0 && since != '0 && !since[NOW_W-1]) begin
         credit = 64'(since) * 64'(rate) / MS_PER_S;
         if (credit >= 64'(win_bytes)) win_bytes = '0;
         else win_bytes = win_bytes - credit[31:0];
      end

      // expired debt clears, otherwise an old window rolls over
      if (debt_end != '0) begin
         win_start = now;
         win_bytes = '0;
         debt_end  = '0;
      end else if (now - win_start >= WINDOW_MS) begin
         win_start = now;
         win_bytes = '0;
      end

      if (32'(len) > 32'(rate)) begin
         // oversize: admit and park ceil(len / rate) windows of debt
         n_windows = (32'(len) + 32'(rate) - 32'd1) / 32'(rate);
         span      = 64'(n_windows) * 64'(WINDOW_MS);
         debt_end  = now + span[31:0];
      end else if (64'(win_bytes) + 64'(len) > 64'(rate)) begin
         d.admitted = 1'b0;
         d.refusal  = REFUSE_FULL;
      end else begin
         win_bytes = win_bytes + 32'(len);
      end
      d.bytes_used = win_bytes[BYTES_W-1:0];
      return d;
   endfunction

   always @(posedge clock) begin : watch
      decision_type want;
      decision_type seen;

      if (reset) begin
         line_baud_q = '0;
         win_start   = '0;
         win_bytes   = '0;
         debt_end    = '0;
         decisions_due.delete();
         fail_count  = 0;
      end else begin
         if (csr_wr_en) line_baud_q = csr_wr_data;

         // decision word leaving the core
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.admitted, rsp_mon.refusal, rsp_mon.bytes_used};
            if (decisions_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected decision word, admitted %0d refusal %0d bytes %0d",
                        $time, seen.admitted, seen.refusal, seen.bytes_used);
            end else begin
               want = decisions_due.pop_front();
               if (seen.admitted !== want.admitted) begin
                  fail_count++;
                  $display("%0t: admitted expected %0d, got %0d",
                           $time, want.admitted, seen.admitted);
               end
               if (seen.refusal !== want.refusal) begin
                  fail_count++;
                  $display("%0t: refusal expected %0d, got %0d",
                           $time, want.refusal, seen.refusal);
               end
               if (seen.bytes_used !== want.bytes_used) begin
                  fail_count++;
                  $display("%0t: bytes_used expected %0d, got %0d",
                           $time, want.bytes_used, seen.bytes_used);
               end
            end
         end

         // offer word entering the core
         if (req_mon.valid && req_mon.ready)
            decisions_due.push_back(judge_offer(req_mon.now_ms, req_mon.msg_len));
      end
      pending_count = decisions_due.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offered-rate limiter testbench top
// Drives offer words and baud settings into the limiter core with random
// gaps and decision-side stalls; the checker beside the core predicts and
// compares every decision word. Directed offers cover the disabled limiter,
// empty offers, window fill, roll-over, debt parking, a debt ending on zero
// and clock wrap; random phases then sweep a range of baud settings.
// ----------------------------------------------------------------------------
module tb_top;
   import orl_pkg::*;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 138;
   localparam int DRAIN_LIMIT     = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [BAUD_W-1:0] csr_wr_data;
   int                fail_count;
   int                pending_count;

   logic [NOW_W-1:0]  clock_ms;
   logic [RATE_W-1:0] cur_rate;
   logic              steady_feed;
   logic [BAUD_W-1:0] phase_baud [PHASES];

   orl_req_if req_bus ();
   orl_rsp_if rsp_bus ();

   offered_rate_admission_limiter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   orl_decision_checker u_decision_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // gap length: mostly none or short, now and then long
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // clock advance between offers: mostly inside a window, sometimes far
   function automatic logic [NOW_W-1:0] ms_step();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return $urandom_range(0, 40);
      if (roll < 80) return $urandom_range(41, 600);
      if (roll < 93) return $urandom_range(601, 3000);
      if (roll < 99) return $urandom_range(3001, 200000);
      return $urandom();
   endfunction

   // offer length shaped around the current line rate
   function automatic logic [LEN_W-1:0] pick_len(input int rate);
      int roll;
      int cap;
      roll = $urandom_range(0, 99);
      cap  = (rate > 65535) ? 65535 : rate;
      if (roll < 2) return '0;
      if (roll < 4) return 16'hFFFF;
      if (roll < 8 || cap == 0) return LEN_W'($urandom_range(0, 65535));
      if (roll < 73) return LEN_W'($urandom_range(1, (cap / 4 > 1) ? cap / 4 : 1));
      if (roll < 88 || rate >= 65535)
         return LEN_W'($urandom_range((cap - cap / 8 > 1) ? cap - cap / 8 : 1, cap));
      return LEN_W'($urandom_range(rate + 1, (3 * rate < 65535) ? 3 * rate : 65535));
   endfunction

   // present one offer word and hold it until accepted; ends on a falling edge
   task automatic offer(input logic [NOW_W-1:0] now, input logic [LEN_W-1:0] len);
      int gap;
      gap = steady_feed ? 0 : idle_span();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.now_ms  <= now;
      req_bus.msg_len <= len;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // baud write once every decision is back
   task automatic set_line_baud(input logic [BAUD_W-1:0] baud);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= baud;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_rate = RATE_W'(baud / LINE_DIV);
   endtask

   // decision side: runs of ready broken by stalls, with long clean runs
   initial begin
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin : sink_loop
         int run;
         int stall;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                           : $urandom_range(1, 6);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(negedge clock);
         stall = idle_span();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int waited;

      req_bus.valid   = 1'b0;
      req_bus.now_ms  = '0;
      req_bus.msg_len = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      steady_feed     = 1'b0;
      cur_rate        = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // limiter off: baud zero, then a baud below ten
      set_line_baud('0);
      offer(32'h1234_5678, 16'hFFFF);
      offer(32'h0000_0000, 16'h0000);
      set_line_baud(22'd7);
      offer(32'd100, 16'd500);

      // one byte per second: fill, roll, debt, debt ending on zero, wrap
      set_line_baud(22'd10);
      offer(32'd0, 16'd1);
      offer(32'd0, 16'd1);
      offer(32'd0, 16'd0);
      offer(32'd500, 16'd1);
      offer(32'd1000, 16'd1);
      offer(32'd1500, 16'd3);
      offer(32'd2000, 16'd1);
      offer(32'd4500, 16'd1);
      offer(32'hFFFF_EC78, 16'd5);
      offer(32'hFFFF_EC80, 16'd1);
      offer(32'd200, 16'd1);
      offer(32'h8000_00C8, 16'd1);
      offer(32'h8000_0100, 16'hFFFF);
      offer(32'h8000_0101, 16'd1);

      // top baud: fill the window with largest offers until it overflows
      set_line_baud(22'h3F_FFFF);
      repeat (7) offer(32'hC000_0000, 16'hFFFF);
      offer(32'hC000_03E8, 16'hFFFF);

      // random phases over a spread of line rates
      phase_baud = '{22'd9600, 22'd4000000, 22'd300, 22'd115200, 22'd10, 22'd1200,
                     22'h3F_FFFF, 22'd57600, 22'd0, 22'd19200, 22'd110, 22'd0};
      phase_baud[PHASES-1] = BAUD_W'($urandom_range(0, 22'h3F_FFFF));
      for (int p = 0; p < PHASES; p++) begin
         set_line_baud(phase_baud[p]);
         case ($urandom_range(0, 3))
            0:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            1:       clock_ms = $urandom_range(0, 50);
            default: clock_ms = $urandom();
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 32 == 0) steady_feed = ($urandom_range(0, 3) == 0);
            clock_ms = clock_ms + ms_step();
            offer(clock_ms, pick_len(int'(cur_rate)));
         end
      end

      // let every decision come back
      req_bus.valid <= 1'b0;
      for (waited = 0; pending_count != 0 && waited < DRAIN_LIMIT; waited++)
         @(negedge clock);
      repeat (100) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("offered_rate_admission_limiter_core verification clean");
      end else begin
         if (pending_count != 0)
            $display("%0t: %0d decision words never arrived", $time, pending_count);
         $display("offered_rate_admission_limiter_core verification failed");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("offered_rate_admission_limiter_core verification failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/orl_pkg.sv
hw/rtl/orl_if.sv
hw/rtl/orl_sdiv.sv
hw/rtl/orl_smul.sv
hw/rtl/offered_rate_admission_limiter_core.sv
tb/orl_decision_checker.sv
tb/tb_top.sv
